@@ src/nmea_pkg.sv @@
package nmea_pkg;

  localparam int LINE_BYTES_DEF       = 128;
  localparam int MAX_SENTENCE_LEN_DEF = 82;

  localparam int BYTE_W = 8;
  localparam int CNT_W  = 8;

  typedef logic [BYTE_W-1:0] byte_t;

  localparam byte_t CH_DOLLAR  = 8'h24;
  localparam byte_t CH_STAR    = 8'h2A;
  localparam byte_t CH_NEWLINE = 8'h0A;
  localparam byte_t CH_NUL     = 8'h00;

  localparam int PREFIX_LEN = 6;

  // "$GPRMC"
  function automatic byte_t prefix_char(input logic [2:0] idx);
    byte_t c;
    case (idx)
      3'd0:    c = 8'h24;
      3'd1:    c = 8'h47;
      3'd2:    c = 8'h50;
      3'd3:    c = 8'h52;
      3'd4:    c = 8'h4D;
      3'd5:    c = 8'h43;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // uppercase ASCII hex digit
  function automatic byte_t hex_char(input logic [3:0] nib);
    byte_t c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else begin
      c = 8'h37 + {4'd0, nib};
    end
    return c;
  endfunction

endpackage

@@ src/nmea_line_checksum_checker_unit.sv @@
// Channel  | Dir | Ports                                                    | Beat
// in_      | in  | in_valid, in_stall, in_rx_byte                           | one rx byte
// out_     | out | out_valid, out_stall, out_line_done, out_checksum_ok,    | one result
//          |     | out_computed_sum, out_success                            |
// One byte per cycle while in_stall is low; the result appears in the cycle after the byte is taken.
// The per-byte update of the line state and the output register form one stage.
// A result waiting in the output register does not block input while out_stall is low.
// in_stall is high only while a result is held and out_stall is high.
// rst_n (synchronous, active low) clears line state, sticky flag and out_valid.
module nmea_line_checksum_checker_unit
  import nmea_pkg::*;
#(
  parameter int LINE_BYTES       = LINE_BYTES_DEF,
  parameter int MAX_SENTENCE_LEN = MAX_SENTENCE_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_line_done,
  output logic        out_checksum_ok,
  output logic [7:0]  out_computed_sum,
  output logic        out_success
);

  localparam logic [2:0] PH_DOLLAR   = 3'd0;
  localparam logic [2:0] PH_SUM      = 3'd1;
  localparam logic [2:0] PH_HEX_HI   = 3'd2;
  localparam logic [2:0] PH_HEX_LO   = 3'd3;
  localparam logic [2:0] PH_COMPLETE = 3'd4;
  localparam logic [2:0] PH_FAIL     = 3'd5;

  localparam logic [CNT_W-1:0] LINE_LIM = LINE_BYTES[CNT_W-1:0];
  localparam logic [CNT_W-1:0] SENT_LIM = MAX_SENTENCE_LEN[CNT_W-1:0];
  localparam logic [CNT_W-1:0] PFX_LIM  = PREFIX_LEN[CNT_W-1:0];

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  byte_t            xor_r, xor_nxt;
  logic [2:0]       phase_r, phase_nxt;
  logic [15:0]      hex_r, hex_nxt;
  logic             pfx_r, pfx_nxt;
  logic             sticky_r, sticky_nxt;

  logic             ovalid_r;
  logic             odone_r, odone_nxt;
  logic             ook_r, ook_nxt;
  byte_t            osum_r, osum_nxt;

  logic             in_acc;
  logic             line_end;
  logic [15:0]      want;

  assign in_stall = ovalid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign line_end = (in_rx_byte == CH_NEWLINE) || (cnt_r >= LINE_LIM);
  assign want     = {hex_char(xor_r[7:4]), hex_char(xor_r[3:0])};

  always_comb begin
    cnt_nxt    = cnt_r;
    xor_nxt    = xor_r;
    phase_nxt  = phase_r;
    hex_nxt    = hex_r;
    pfx_nxt    = pfx_r;
    sticky_nxt = sticky_r;
    odone_nxt  = 1'b0;
    ook_nxt    = 1'b0;
    if (line_end) begin
      odone_nxt = 1'b1;
      ook_nxt   = (phase_r == PH_COMPLETE) && (hex_r == want);
      if (ook_nxt) begin
        sticky_nxt = pfx_r && (cnt_r >= PFX_LIM);
      end
      osum_nxt  = xor_r;
      cnt_nxt   = '0;
      xor_nxt   = '0;
      phase_nxt = PH_DOLLAR;
      hex_nxt   = '0;
      pfx_nxt   = 1'b1;
    end else begin
      if ((cnt_r < PFX_LIM) && (in_rx_byte != prefix_char(cnt_r[2:0]))) begin
        pfx_nxt = 1'b0;
      end
      case (phase_r)
        PH_DOLLAR: begin
          phase_nxt = (in_rx_byte == CH_DOLLAR) ? PH_SUM : PH_FAIL;
        end
        PH_SUM: begin
          if ((cnt_r >= SENT_LIM) || (in_rx_byte == CH_NUL)) begin
            phase_nxt = PH_FAIL;
          end else if (in_rx_byte == CH_STAR) begin
            phase_nxt = PH_HEX_HI;
          end else begin
            xor_nxt = xor_r ^ in_rx_byte;
          end
        end
        PH_HEX_HI: begin
          hex_nxt   = {in_rx_byte, 8'h00};
          phase_nxt = PH_HEX_LO;
        end
        PH_HEX_LO: begin
          hex_nxt   = {hex_r[15:8], in_rx_byte};
          phase_nxt = PH_COMPLETE;
        end
        default: begin
        end
      endcase
      cnt_nxt  = cnt_r + 1'b1;
      osum_nxt = xor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      xor_r    <= '0;
      phase_r  <= PH_DOLLAR;
      hex_r    <= '0;
      pfx_r    <= 1'b1;
      sticky_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        cnt_r    <= cnt_nxt;
        xor_r    <= xor_nxt;
        phase_r  <= phase_nxt;
        hex_r    <= hex_nxt;
        pfx_r    <= pfx_nxt;
        sticky_r <= sticky_nxt;
        ovalid_r <= 1'b1;
      end else if (!out_stall) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      odone_r <= odone_nxt;
      ook_r   <= ook_nxt;
      osum_r  <= osum_nxt;
    end
  end

  assign out_valid        = ovalid_r;
  assign out_line_done    = odone_r;
  assign out_checksum_ok  = ook_r;
  assign out_computed_sum = osum_r;
  assign out_success      = sticky_r;

  a_ok_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_checksum_ok |-> out_line_done)
    else $error("checksum_ok without line_done");

  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && line_end |=> (cnt_r == '0) && (xor_r == '0) && (phase_r == PH_DOLLAR))
    else $error("line state not cleared after line end");

  a_sticky_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_acc && line_end) |=> $stable(sticky_r))
    else $error("sticky flag changed without line end");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LINE_LIM)
    else $error("byte count beyond line store");

endmodule

@@ tb/tb.sv @@
module tb;
  import nmea_pkg::*;

  typedef enum logic [2:0] {
    SCAN_DOLLAR, SCAN_SUM, SCAN_HEX_HI, SCAN_HEX_LO, SCAN_DONE, SCAN_FAIL
  } scan_phase_e;

  typedef struct packed {
    logic  done;
    logic  ok;
    byte_t sum;
    logic  success;
  } line_verdict_t;

  localparam logic [47:0] RMC_TAG = "$GPRMC";

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_line_done;
  logic       out_checksum_ok;
  logic [7:0] out_computed_sum;
  logic       out_success;

  nmea_line_checksum_checker_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_line_done   (out_line_done),
    .out_checksum_ok (out_checksum_ok),
    .out_computed_sum(out_computed_sum),
    .out_success     (out_success)
  );

  byte_t         pending_bytes[$];
  line_verdict_t verdicts_due[$];
  int            total_bytes = 0;
  int            bytes_taken = 0;
  int            fault_count = 0;
  int            tx_gap = 0;
  int            rx_gap = 0;
  int            hold_left = 0;
  bit            hold_fired = 1'b0;

  // line tracker state
  int          held = 0;
  byte_t       sum_acc = '0;
  scan_phase_e phase = SCAN_DOLLAR;
  logic [15:0] got_hex = '0;
  bit          prefix_ok = 1'b1;
  bit          sticky = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic byte_t upper_hex(logic [3:0] n);
    if (n < 4'd10) begin
      return byte_t'(8'h30 + n);
    end
    return byte_t'(8'h41 + n - 8'd10);
  endfunction

  function automatic byte_t filler();
    byte_t c;
    if ($urandom_range(0, 9) == 0) begin
      c = byte_t'($urandom_range(1, 255));
    end else begin
      c = byte_t'($urandom_range(8'h20, 8'h7E));
    end
    if (c == CH_STAR || c == CH_NEWLINE) begin
      c = 8'h2C;
    end
    return c;
  endfunction

  // quiet at the tail and in one of every three stretches
  function automatic bit idling_allowed();
    return (bytes_taken < total_bytes - 200) && ((bytes_taken / 250) % 3 != 2);
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0h, want %0h (beat %0d)", what, got, want, bytes_taken);
    fault_count++;
  endtask

  task automatic judge_byte(byte_t b);
    line_verdict_t v;
    v = '0;
    if (b != CH_NEWLINE && held < LINE_BYTES_DEF) begin
      if (held < PREFIX_LEN && b != RMC_TAG[47 - 8*held -: 8]) begin
        prefix_ok = 1'b0;
      end
      case (phase)
        SCAN_DOLLAR: begin
          phase = (b == CH_DOLLAR) ? SCAN_SUM : SCAN_FAIL;
        end
        SCAN_SUM: begin
          if (held >= MAX_SENTENCE_LEN_DEF || b == CH_NUL) begin
            phase = SCAN_FAIL;
          end else if (b == CH_STAR) begin
            phase = SCAN_HEX_HI;
          end else begin
            sum_acc ^= b;
          end
        end
        SCAN_HEX_HI: begin
          got_hex = {b, 8'h00};
          phase = SCAN_HEX_LO;
        end
        SCAN_HEX_LO: begin
          got_hex[7:0] = b;
          phase = SCAN_DONE;
        end
        default: ;
      endcase
      held++;
      v.sum = sum_acc;
    end else begin
      v.done = 1'b1;
      v.ok = (phase == SCAN_DONE) &&
             (got_hex == {upper_hex(sum_acc[7:4]), upper_hex(sum_acc[3:0])});
      if (v.ok) begin
        sticky = prefix_ok && (held >= PREFIX_LEN);
      end
      v.sum = sum_acc;
      held = 0;
      sum_acc = '0;
      phase = SCAN_DOLLAR;
      got_hex = '0;
      prefix_ok = 1'b1;
    end
    v.success = sticky;
    verdicts_due.push_back(v);
  endtask

  task automatic put(byte_t b);
    pending_bytes.push_back(b);
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put(byte_t'(s[i]));
  endtask

  // '*' lands at position star_at; the tag fills the start of the sentence
  task automatic put_sentence(string tag, int star_at, bit good_sum, bit with_nl);
    byte_t c;
    byte_t sum;
    int    i;
    sum = '0;
    put(CH_DOLLAR);
    for (i = 1; i < star_at; i++) begin
      c = (i - 1 < tag.len()) ? byte_t'(tag[i-1]) : filler();
      sum ^= c;
      put(c);
    end
    put(CH_STAR);
    if (good_sum) begin
      put(upper_hex(sum[7:4]));
      put(upper_hex(sum[3:0]));
    end else begin
      case ($urandom_range(0, 2))
        0: begin
          put(upper_hex(sum[7:4]) ^ 8'h20);
          put(upper_hex(sum[3:0]));
        end
        1: begin
          put(upper_hex(sum[7:4]));
          put(upper_hex(sum[3:0] ^ 4'h1));
        end
        default: put(upper_hex(sum[7:4]));
      endcase
    end
    repeat ($urandom_range(0, 3)) put(filler());
    if (with_nl) begin
      put(CH_NEWLINE);
    end
  endtask

  initial begin
    string tag;
    int    star_at;
    int    n;
    put_text("$GPRMC*4B");
    put(CH_NEWLINE);
    put(CH_NEWLINE);
    put_text("$*00");
    put(CH_NEWLINE);
    put(CH_DOLLAR);
    put(CH_NUL);
    put(8'hFF);
    put(CH_NEWLINE);
    put(CH_DOLLAR);
    put(8'hFF);
    put_text("*F");
    put(CH_NEWLINE);

    while (pending_bytes.size() < 1525) begin
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 3))
          0, 1: tag = "GPRMC";
          2:    tag = "GPGGA";
          default: tag = "GNRMC";
        endcase
        n = $urandom_range(0, 19);
        if (n < 14) begin
          star_at = $urandom_range(1, 30);
        end else if (n < 17) begin
          star_at = $urandom_range(78, 84);
        end else begin
          star_at = $urandom_range(85, 140);
        end
        put_sentence(tag, star_at, $urandom_range(0, 4) != 0, $urandom_range(0, 9) != 0);
      end else begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(125, 140) : $urandom_range(0, 20);
        repeat (n) put(byte_t'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) != 0) begin
          put(CH_NEWLINE);
        end
      end
    end
    total_bytes = pending_bytes.size();

    @(posedge clk);
    while (!rst_n || bytes_taken != total_bytes) @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fault_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(12 * 600000);
    $display("RESULT: ERROR");
    $finish;
  end

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        judge_byte(in_rx_byte);
        bytes_taken <= bytes_taken + 1;
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap != 0) begin
          tx_gap <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          in_rx_byte <= pending_bytes.pop_front();
          in_valid <= 1'b1;
          if (idling_allowed() && $urandom_range(0, 7) == 0) begin
            tx_gap <= $urandom_range(1, 13);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off to back up the input side
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_fired && bytes_taken >= 300) begin
      hold_left <= 80;
      hold_fired <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver and checker
  always @(posedge clk) begin : rx_side
    line_verdict_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          flag_mismatch("unexpected beat", 1, 0);
        end else begin
          want = verdicts_due.pop_front();
          if (out_line_done !== want.done)
            flag_mismatch("line_done", out_line_done, want.done);
          if (out_checksum_ok !== want.ok)
            flag_mismatch("checksum_ok", out_checksum_ok, want.ok);
          if (out_computed_sum !== want.sum)
            flag_mismatch("computed_sum", out_computed_sum, want.sum);
          if (out_success !== want.success)
            flag_mismatch("success", out_success, want.success);
        end
      end
      if (rx_gap != 0) begin
        rx_gap <= rx_gap - 1;
        out_stall <= 1'b1;
      end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
        rx_gap <= $urandom_range(0, 12);
        out_stall <= 1'b1;
      end else begin
        out_stall <= (hold_left != 0);
      end
    end
  end

endmodule
